[sv/preemptive_priority_scheduler_macros.svh]
// Assertion macros shared by the scheduler checks.
// Both sample on clk and are switched off while rst_n is low.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define PPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication.
`define PPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[sv/pps_pkg.sv]
package pps_pkg;

    localparam int MAX_JOBS = 16;
    localparam int ID_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int COUNT_W  = $clog2(MAX_JOBS + 1);
    localparam int TIME_W   = 16;
    localparam int PRI_W    = 8;
    localparam int JOB_ID_W = 4;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_JOBS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_EMIT
    } state_t;

    // Best candidate so far, passed down the chain.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] start;
    } cand_t;

    // Broadcast from controller to every cell.
    typedef struct packed {
        logic               load;
        logic               commit;
        logic [ID_W-1:0]    slot;
        logic [TIME_W-1:0]  arrival;
        logic [TIME_W-1:0]  burst;
        logic [PRI_W-1:0]   pri;
        logic [TIME_W-1:0]  now;
        logic [COUNT_W-1:0] count;
    } bcast_t;

endpackage

[sv/pps_cell.sv]
module pps_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [pps_pkg::ID_W-1:0] cell_idx,
    input  pps_pkg::bcast_t        bcast,
    input  pps_pkg::cand_t         cand_in,
    output pps_pkg::cand_t         cand_out
);
    import pps_pkg::*;

    logic [TIME_W-1:0] arrival_reg;
    logic [TIME_W-1:0] burst_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [TIME_W-1:0] remaining_reg;
    logic [TIME_W-1:0] start_reg;
    logic              done_reg;
    cand_t             cand_reg;
    cand_t             cand_next;

    logic hit_load;
    logic hit_commit;
    logic ready;
    logic better;

    assign hit_load   = bcast.load && (bcast.slot == cell_idx);
    assign hit_commit = bcast.commit && (bcast.slot == cell_idx);

    // slot payload
    always_ff @(posedge clk)
    begin
        if (hit_load)
        begin
            arrival_reg   <= bcast.arrival;
            burst_reg     <= bcast.burst;
            pri_reg       <= bcast.pri;
            remaining_reg <= bcast.burst;
        end
        else if (hit_commit)
        begin
            remaining_reg <= remaining_reg - TIME_W'(1);
            if (remaining_reg == burst_reg)
            begin
                start_reg <= bcast.now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (hit_load)
        begin
            done_reg <= (bcast.burst == '0);
        end
        else if (hit_commit && (remaining_reg == TIME_W'(1)))
        begin
            done_reg <= 1'b1;
        end
    end

    // loaded, unfinished, arrived
    assign ready = (COUNT_W'(cell_idx) < bcast.count) && !done_reg
                   && (arrival_reg <= bcast.now);

    // strict compare keeps the lower slot on a full tie
    assign better = ready && (!cand_in.valid || (pri_reg > cand_in.pri)
                    || ((pri_reg == cand_in.pri) && (arrival_reg < cand_in.arrival)));

    always_comb
    begin
        if (better)
        begin
            cand_next.valid     = 1'b1;
            cand_next.id        = cell_idx;
            cand_next.pri       = pri_reg;
            cand_next.arrival   = arrival_reg;
            cand_next.burst     = burst_reg;
            cand_next.remaining = remaining_reg;
            cand_next.start     = start_reg;
        end
        else
        begin
            cand_next = cand_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

[sv/pps_ctrl.sv]
module pps_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          operation,
    input  logic [pps_pkg::TIME_W-1:0]    arrival_time,
    input  logic [pps_pkg::TIME_W-1:0]    burst_length,
    input  logic [pps_pkg::PRI_W-1:0]     job_priority,
    input  pps_pkg::cand_t                tail,
    output pps_pkg::bcast_t               bcast,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          ran,
    output logic [pps_pkg::JOB_ID_W-1:0]  job_id,
    output logic                          finished,
    output logic [pps_pkg::TIME_W-1:0]    completion_time,
    output logic [pps_pkg::TIME_W-1:0]    turnaround_time,
    output logic [pps_pkg::TIME_W-1:0]    waiting_time,
    output logic [pps_pkg::TIME_W-1:0]    response_time
);
    import pps_pkg::*;

    state_t             state_reg, state_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]    scan_reg, scan_next;
    logic               out_valid_reg, out_valid_next;

    // tick result held between apply and emit
    logic                res_ran_reg, res_ran_next;
    logic [JOB_ID_W-1:0] res_id_reg, res_id_next;
    logic                res_fin_reg, res_fin_next;
    logic [TIME_W-1:0]   res_ct_reg, res_ct_next;
    logic [TIME_W-1:0]   res_tat_reg, res_tat_next;
    logic [TIME_W-1:0]   res_rt_reg, res_rt_next;
    logic [TIME_W-1:0]   res_burst_reg, res_burst_next;

    // output register
    logic                ran_reg, ran_next;
    logic [JOB_ID_W-1:0] job_id_reg, job_id_next;
    logic                fin_reg, fin_next;
    logic [TIME_W-1:0]   ct_reg, ct_next;
    logic [TIME_W-1:0]   tat_reg, tat_next;
    logic [TIME_W-1:0]   wt_reg, wt_next;
    logic [TIME_W-1:0]   rt_reg, rt_next;

    logic               accept;
    logic               emit;
    logic [TIME_W-1:0]  time_inc;
    logic [TIME_W-1:0]  start_eff;
    logic               tail_fin;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign time_inc   = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_W'(1);
    assign start_eff  = (tail.remaining == tail.burst) ? time_reg : tail.start;
    assign tail_fin   = tail.valid && (tail.remaining == TIME_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        res_ran_next   = res_ran_reg;
        res_id_next    = res_id_reg;
        res_fin_next   = res_fin_reg;
        res_ct_next    = res_ct_reg;
        res_tat_next   = res_tat_reg;
        res_rt_next    = res_rt_reg;
        res_burst_next = res_burst_reg;
        emit           = 1'b0;

        bcast.load    = 1'b0;
        bcast.commit  = 1'b0;
        bcast.slot    = count_reg[ID_W-1:0];
        bcast.arrival = arrival_time;
        bcast.burst   = burst_length;
        bcast.pri     = job_priority;
        bcast.now     = time_reg;
        bcast.count   = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_LOAD))
                begin
                    if (count_reg < COUNT_MAX)
                    begin
                        bcast.load = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                else if (accept && (operation == OP_TICK))
                begin
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + ID_W'(1);
                if (scan_reg == ID_W'(MAX_JOBS - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                bcast.commit   = tail.valid;
                bcast.slot     = tail.id;
                time_next      = time_inc;
                res_ran_next   = tail.valid;
                res_id_next    = tail.valid ? JOB_ID_W'(tail.id) : '0;
                res_fin_next   = tail_fin;
                res_ct_next    = tail_fin ? time_inc : '0;
                res_tat_next   = tail_fin ? time_inc - tail.arrival : '0;
                res_rt_next    = tail_fin ? start_eff - tail.arrival : '0;
                res_burst_next = tail.burst;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = (out_valid_reg && !result_ready) || emit;
        ran_next       = ran_reg;
        job_id_next    = job_id_reg;
        fin_next       = fin_reg;
        ct_next        = ct_reg;
        tat_next       = tat_reg;
        wt_next        = wt_reg;
        rt_next        = rt_reg;
        if (emit)
        begin
            ran_next    = res_ran_reg;
            job_id_next = res_id_reg;
            fin_next    = res_fin_reg;
            ct_next     = res_ct_reg;
            tat_next    = res_tat_reg;
            rt_next     = res_rt_reg;
            // clamps at zero once time has saturated
            wt_next     = (res_fin_reg && (res_tat_reg >= res_burst_reg))
                          ? res_tat_reg - res_burst_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ran_reg   <= res_ran_next;
        res_id_reg    <= res_id_next;
        res_fin_reg   <= res_fin_next;
        res_ct_reg    <= res_ct_next;
        res_tat_reg   <= res_tat_next;
        res_rt_reg    <= res_rt_next;
        res_burst_reg <= res_burst_next;
        ran_reg       <= ran_next;
        job_id_reg    <= job_id_next;
        fin_reg       <= fin_next;
        ct_reg        <= ct_next;
        tat_reg       <= tat_next;
        wt_reg        <= wt_next;
        rt_reg        <= rt_next;
    end

    assign result_valid    = out_valid_reg;
    assign ran             = ran_reg;
    assign job_id          = job_id_reg;
    assign finished        = fin_reg;
    assign completion_time = ct_reg;
    assign turnaround_time = tat_reg;
    assign waiting_time    = wt_reg;
    assign response_time   = rt_reg;

endmodule

[sv/preemptive_priority_scheduler.sv]
// Channel   Handshake                   Payload
// item      item_valid / item_ready     operation, arrival_time, burst_length, job_priority
// result    result_valid / result_ready ran, job_id, finished, completion_time,
//                                       turnaround_time, waiting_time, response_time
//
// A load transaction leaves item_ready high. A tick holds item_ready low after acceptance
// while the best-candidate record ripples through the cell chain (ST_SCAN), while the
// winner is committed (ST_APPLY) and until the result is emitted (ST_EMIT).
// rst_n (async, active low) clears time, job count and the per-slot done flags.
// A stalled result only holds the tick in its emit state while the output register
// is still full; loads are accepted while a result waits.
module preemptive_priority_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          operation,
    input  logic [pps_pkg::TIME_W-1:0]    arrival_time,
    input  logic [pps_pkg::TIME_W-1:0]    burst_length,
    input  logic [pps_pkg::PRI_W-1:0]     job_priority,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          ran,
    output logic [pps_pkg::JOB_ID_W-1:0]  job_id,
    output logic                          finished,
    output logic [pps_pkg::TIME_W-1:0]    completion_time,
    output logic [pps_pkg::TIME_W-1:0]    turnaround_time,
    output logic [pps_pkg::TIME_W-1:0]    waiting_time,
    output logic [pps_pkg::TIME_W-1:0]    response_time
);
    import pps_pkg::*;

    // Link k feeds cell k; link 0 is the empty candidate, the last link is the winner.
    cand_t  link [MAX_JOBS+1];
    bcast_t bcast;

    assign link[0] = '0;

    // One cell per job slot. Each compares its own job against the record
    // from its left neighbour and registers the better of the two.
    for (genvar k = 0; k < MAX_JOBS; k++)
    begin : g_cell
        pps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (ID_W'(k)),
            .bcast    (bcast),
            .cand_in  (link[k]),
            .cand_out (link[k+1])
        );
    end

    // Sequencer: time and job count, scan timing, commit and result register.
    pps_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .arrival_time    (arrival_time),
        .burst_length    (burst_length),
        .job_priority    (job_priority),
        .tail            (link[MAX_JOBS]),
        .bcast           (bcast),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .ran             (ran),
        .job_id          (job_id),
        .finished        (finished),
        .completion_time (completion_time),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .response_time   (response_time)
    );

endmodule

[sv/pps_checker.sv]
`include "preemptive_priority_scheduler_macros.svh"

module pps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          operation,
    input logic [pps_pkg::TIME_W-1:0]    arrival_time,
    input logic [pps_pkg::TIME_W-1:0]    burst_length,
    input logic [pps_pkg::PRI_W-1:0]     job_priority,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic                          ran,
    input logic [pps_pkg::JOB_ID_W-1:0]  job_id,
    input logic                          finished,
    input logic [pps_pkg::TIME_W-1:0]    completion_time,
    input logic [pps_pkg::TIME_W-1:0]    turnaround_time,
    input logic [pps_pkg::TIME_W-1:0]    waiting_time,
    input logic [pps_pkg::TIME_W-1:0]    response_time
);
    // stalled result holds
    `PPS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(job_id) && $stable(completion_time) && $stable(ran))

    // idle tick carries nothing
    `PPS_ASSERT_NOW(a_idle_clean, result_valid && !ran, job_id == '0 && !finished)

    // figures only on completion
    `PPS_ASSERT_NOW(a_figures_gated, result_valid && !finished, completion_time == '0 && turnaround_time == '0 && waiting_time == '0 && response_time == '0)

    // wait and response never exceed turnaround
    `PPS_ASSERT_NOW(a_figure_order, result_valid && finished, ran && waiting_time <= turnaround_time && response_time <= turnaround_time)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
